// ----- design/hcp_pkg.sv -----
// Shared constants and types for the Huffman code packer.
package hcp_pkg;

   localparam int MAX_CODE_LEN   = 16;
   localparam int SYMBOL_COUNT   = 256;
   localparam int CODE_WORD_BITS = 16;
   localparam int LEN_CAP        = (MAX_CODE_LEN < CODE_WORD_BITS) ? MAX_CODE_LEN
                                                                   : CODE_WORD_BITS;

   localparam int IQ_DEPTH      = 2;
   localparam int IQ_PTR_BITS   = 1;
   localparam int IQ_COUNT_BITS = $clog2(IQ_DEPTH + 1);
   localparam int RQ_DEPTH      = 4;
   localparam int RQ_PTR_BITS   = 2;
   localparam int RQ_COUNT_BITS = $clog2(RQ_DEPTH + 1);

   localparam logic [1:0] MODE_LOAD   = 2'd0;
   localparam logic [1:0] MODE_ENCODE = 2'd1;
   localparam logic [1:0] MODE_FLUSH  = 2'd2;

   typedef enum logic [1:0] {
      KIND_ENCODE = 2'd0,
      KIND_MISS   = 2'd1,
      KIND_FLUSH  = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type                  kind;
      logic [CODE_WORD_BITS-1:0] code;
      logic [4:0]                length;
   } item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_count;
      logic       is_last;
      logic       error;
   } result_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ----- design/hcp_front.sv -----
// Front end: request acceptance, code table, valid bits and classification.
module hcp_front import hcp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  logic [1:0]       req_mode,
   input  logic [7:0]       req_symbol,
   input  logic [15:0]      req_code_word,
   input  logic [4:0]       req_code_length,
   input  queue_status_type iq_status,
   output logic             req_full,
   output logic             item_valid,
   output item_type         item
);

   logic [CODE_WORD_BITS-1:0] code_mem [SYMBOL_COUNT];
   logic [4:0]                len_mem  [SYMBOL_COUNT];

   logic [SYMBOL_COUNT-1:0]   entry_valid_ff, entry_valid_in;
   logic                      s1_valid_ff, s1_valid_in;
   kind_type                  s1_kind_ff;
   logic                      s1_hit_ff;
   logic [CODE_WORD_BITS-1:0] code_ff;
   logic [4:0]                len_ff;

   logic       accept, in_range, do_load, do_work;
   logic [4:0] len_capped;

   assign req_full   = s1_valid_ff && iq_status.full;
   assign accept     = req_push && !req_full;
   assign in_range   = {1'b0, req_symbol} < 9'(SYMBOL_COUNT);
   assign do_load    = accept && (req_mode == MODE_LOAD) && in_range;
   assign do_work    = accept && ((req_mode == MODE_ENCODE) || (req_mode == MODE_FLUSH));
   assign len_capped = (req_code_length > 5'(LEN_CAP)) ? 5'(LEN_CAP) : req_code_length;

   always_comb begin
      entry_valid_in = entry_valid_ff;
      if (do_load) begin
         entry_valid_in[req_symbol] = 1'b1;
      end
   end

   always_comb begin
      if (do_work) begin
         s1_valid_in = 1'b1;
      end else if (s1_valid_ff && !iq_status.full) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         s1_valid_ff    <= 1'b0;
      end else begin
         entry_valid_ff <= entry_valid_in;
         s1_valid_ff    <= s1_valid_in;
      end
   end

   // table write and registered read
   always_ff @(posedge clock) begin
      if (do_load) begin
         code_mem[req_symbol] <= req_code_word;
         len_mem[req_symbol]  <= len_capped;
      end
      if (do_work) begin
         code_ff <= code_mem[req_symbol];
         len_ff  <= len_mem[req_symbol];
      end
   end

   always_ff @(posedge clock) begin
      if (do_work) begin
         s1_kind_ff <= (req_mode == MODE_FLUSH) ? KIND_FLUSH : KIND_ENCODE;
         s1_hit_ff  <= in_range && entry_valid_ff[req_symbol];
      end
   end

   assign item_valid  = s1_valid_ff;
   assign item.kind   = ((s1_kind_ff == KIND_ENCODE) && !s1_hit_ff) ? KIND_MISS : s1_kind_ff;
   assign item.code   = code_ff;
   assign item.length = len_ff;

endmodule

// ----- design/hcp_item_queue.sv -----
// Two-entry queue of classified requests between front and back end.
module hcp_item_queue import hcp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  item_type         push_item,
   input  logic             pop,
   output queue_status_type status,
   output item_type         head
);

   item_type                 slot_ff [IQ_DEPTH];
   logic [IQ_PTR_BITS-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [IQ_COUNT_BITS-1:0] count_ff, count_in;

   assign count_in = count_ff + IQ_COUNT_BITS'(push) - IQ_COUNT_BITS'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign status.full  = (count_ff == IQ_COUNT_BITS'(IQ_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head         = slot_ff[rd_ptr_ff];

endmodule

// ----- design/hcp_back.sv -----
// Back end: bit packer, pending byte state and result queue.
module hcp_back import hcp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type iq_status,
   input  item_type         head,
   output logic             iq_pop,
   input  logic             rsp_pop,
   output logic             rsp_empty,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_is_count,
   output logic             rsp_is_last,
   output logic             rsp_error
);

   logic [7:0]               pend_byte_ff, pend_byte_in;
   logic [2:0]               pend_count_ff, pend_count_in;
   result_type               rq_ff [RQ_DEPTH];
   logic [RQ_PTR_BITS-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [RQ_COUNT_BITS-1:0] count_ff, count_in;

   logic        go, pop_ok;
   logic [1:0]  n_res;
   result_type  res0, res1;
   logic [31:0] code_wide;
   logic [15:0] code_lj;
   logic [23:0] window;
   logic [4:0]  total;

   // room for two results before taking the next request
   assign go     = !iq_status.empty && (count_ff <= RQ_COUNT_BITS'(RQ_DEPTH - 2));
   assign iq_pop = go;
   assign pop_ok = rsp_pop && !rsp_empty;

   assign code_wide = {16'b0, head.code} << (5'(CODE_WORD_BITS) - head.length);
   assign code_lj   = code_wide[15:0];
   assign window    = {pend_byte_ff, 16'b0} | ({code_lj, 8'b0} >> pend_count_ff);
   assign total     = 5'(pend_count_ff) + head.length;

   always_comb begin
      n_res         = 2'd0;
      res0          = '0;
      res1          = '0;
      pend_byte_in  = pend_byte_ff;
      pend_count_in = pend_count_ff;
      case (head.kind)
         KIND_ENCODE: begin
            n_res          = total[4:3];
            res0.out_byte  = window[23:16];
            res0.is_last   = (total[4:3] == 2'd1);
            res1.out_byte  = window[15:8];
            res1.is_last   = 1'b1;
            pend_count_in  = total[2:0];
            case (total[4:3])
               2'd0:    pend_byte_in = window[23:16];
               2'd1:    pend_byte_in = window[15:8];
               default: pend_byte_in = window[7:0];
            endcase
         end
         KIND_MISS: begin
            n_res        = 2'd1;
            res0.is_last = 1'b1;
            res0.error   = 1'b1;
         end
         KIND_FLUSH: begin
            n_res         = (pend_count_ff != 3'd0) ? 2'd2 : 2'd0;
            res0.out_byte = pend_byte_ff;
            res1.out_byte = {5'b0, pend_count_ff};
            res1.is_count = 1'b1;
            res1.is_last  = 1'b1;
            pend_byte_in  = 8'd0;
            pend_count_in = 3'd0;
         end
         default: begin
            n_res = 2'd0;
         end
      endcase
   end

   assign count_in = count_ff + (go ? RQ_COUNT_BITS'(n_res) : '0)
                   - RQ_COUNT_BITS'(pop_ok);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_byte_ff  <= 8'd0;
         pend_count_ff <= 3'd0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
      end else begin
         if (go) begin
            pend_byte_ff  <= pend_byte_in;
            pend_count_ff <= pend_count_in;
            wr_ptr_ff     <= wr_ptr_ff + RQ_PTR_BITS'(n_res);
         end
         if (pop_ok) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (go && (n_res != 2'd0)) begin
         rq_ff[wr_ptr_ff] <= res0;
      end
      if (go && (n_res == 2'd2)) begin
         rq_ff[wr_ptr_ff + 1'b1] <= res1;
      end
   end

   assign rsp_empty    = (count_ff == '0);
   assign rsp_out_byte = rq_ff[rd_ptr_ff].out_byte;
   assign rsp_is_count = rq_ff[rd_ptr_ff].is_count;
   assign rsp_is_last  = rq_ff[rd_ptr_ff].is_last;
   assign rsp_error    = rq_ff[rd_ptr_ff].error;

endmodule

// ----- design/huffman_code_packer_unit.sv -----
// Top level of the Huffman code packer: front end, request queue and back end.
//
// Huffman encoder with a loadable 256-entry code table. Mode 0 loads one
// symbol's code (right-aligned) and length, lengths above 16 saturate to 16.
// Mode 1 appends the symbol's code, first bit first, into a byte filling from
// its MSB and returns each byte completed (zero to two per request, is_last
// on the final one); an unloaded symbol returns one result with error set.
// Mode 2 returns the partial byte, then a count byte (is_count) of the bits
// used, and clears the packer; with nothing pending it returns nothing. Loads
// and mode 3 return nothing. Requests are taken one per cycle while req_full
// is low: the table read is a single registered lookup in the front end and
// the packer handles a whole code (up to 16 bits) at once. A request's first
// result passes the front-end register, request queue and result queue on
// its way out. Results leave one per pop from a four-entry result queue, so
// a run of requests that each give two results is paced by the pop side.
// The table's valid bits clear at reset; no clearing pass is needed.
module huffman_code_packer_unit import hcp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_mode,
   input  logic [7:0]  req_symbol,
   input  logic [15:0] req_code_word,
   input  logic [4:0]  req_code_length,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_is_count,
   output logic        rsp_is_last,
   output logic        rsp_error
);

   queue_status_type iq_status;
   item_type         front_item, head_item;
   logic             front_valid, iq_push, iq_pop;

   // classified request moves on whenever the queue has room
   assign iq_push = front_valid && !iq_status.full;

   hcp_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_mode        (req_mode),
      .req_symbol      (req_symbol),
      .req_code_word   (req_code_word),
      .req_code_length (req_code_length),
      .iq_status       (iq_status),
      .req_full        (req_full),
      .item_valid      (front_valid),
      .item            (front_item)
   );

   hcp_item_queue u_item_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (iq_push),
      .push_item (front_item),
      .pop       (iq_pop),
      .status    (iq_status),
      .head      (head_item)
   );

   hcp_back u_back (
      .clock        (clock),
      .reset        (reset),
      .iq_status    (iq_status),
      .head         (head_item),
      .iq_pop       (iq_pop),
      .rsp_pop      (rsp_pop),
      .rsp_empty    (rsp_empty),
      .rsp_out_byte (rsp_out_byte),
      .rsp_is_count (rsp_is_count),
      .rsp_is_last  (rsp_is_last),
      .rsp_error    (rsp_error)
   );

   // an error result is a lone, empty, final result
   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_error) |->
         (rsp_is_last && !rsp_is_count && (rsp_out_byte == 8'd0)))
      else $error("malformed error result");

   // the used-bit count closes a flush and lies between one and seven
   a_count_shape: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_is_count) |->
         (rsp_is_last && !rsp_error && (rsp_out_byte != 8'd0) && (rsp_out_byte[7:3] == 5'd0)))
      else $error("malformed count result");

   // the result queue only drains through pops
   a_empty_by_pop: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_empty) |-> $past(rsp_pop))
      else $error("result queue emptied without a pop");

   // the front end holds requests off only while the request queue is full
   a_full_cause: assert property (@(posedge clock) disable iff (reset)
      req_full |-> (front_valid && iq_status.full && !iq_push))
      else $error("request stall without a full queue");

endmodule

// ----- tb/huffman_code_packer_unit_test.sv -----
// Self-checking testbench for the Huffman code packer: scoreboard, drivers and run sequence.
`timescale 1ns / 100ps

module huffman_code_packer_unit_test import hcp_pkg::*; ();

   // Mode 3 has no meaning in the block; it is sent to prove it is ignored.
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   localparam int CLK_PERIOD        = 10;
   localparam int RESET_CYCLES      = 10;
   localparam int PHASE_REQUESTS    = 217;
   localparam int POOL_SIZE         = 24;
   localparam int LONG_STALL_CYCLES = 300;
   // Time left after the last drain for stragglers to show; a good margin.
   localparam int DRAIN_CYCLES      = 16;
   localparam int CYCLE_LIMIT       = 200000;

   // ---------------------------------------------------------------------
   // Scoreboard: own copy of the code table and the byte packer. Every
   // accepted request is run through it; the bytes it would send out are
   // queued and each popped result is checked against the oldest of them.
   // ---------------------------------------------------------------------
   class packer_scoreboard;
      logic [15:0] code_tab [SYMBOL_COUNT];
      logic [4:0]  len_tab [SYMBOL_COUNT];
      bit          valid_tab [SYMBOL_COUNT];
      logic [7:0]  pend_byte;
      logic [2:0]  pend_count;
      result_type  bytes_due [$];
      int mismatches, n_checked;
      int n_loads, n_encodes, n_misses, n_flushes, n_ignored;

      function new();
         foreach (valid_tab[k]) valid_tab[k] = 1'b0;
         pend_byte  = '0;
         pend_count = '0;
      endfunction

      function int outstanding();
         return bytes_due.size();
      endfunction

      function void note_request(logic [1:0] mode, logic [7:0] sym,
                                 logic [15:0] word, logic [4:0] len);
         int         clen;
         logic [15:0] code;
         result_type held;
         bit         have_held;
         have_held = 1'b0;
         case (mode)
            MODE_LOAD: begin
               n_loads++;
               if (int'(sym) < SYMBOL_COUNT) begin
                  code_tab[sym]  = word;
                  len_tab[sym]   = (int'(len) > LEN_CAP) ? 5'(LEN_CAP) : len;
                  valid_tab[sym] = 1'b1;
               end
            end
            MODE_ENCODE: begin
               n_encodes++;
               if (int'(sym) >= SYMBOL_COUNT || !valid_tab[sym]) begin
                  // unknown symbol: single error result, packer untouched
                  n_misses++;
                  bytes_due.push_back('{out_byte: 8'h00, is_count: 1'b0,
                                        is_last: 1'b1, error: 1'b1});
               end else begin
                  clen = int'(len_tab[sym]);
                  code = code_tab[sym];
                  // first bit sent is the top bit of the code
                  for (int i = clen - 1; i >= 0; i--) begin
                     if (code[i]) pend_byte[3'd7 - pend_count] = 1'b1;
                     if (pend_count == 3'd7) begin
                        if (have_held) bytes_due.push_back(held);
                        held = '{out_byte: pend_byte, is_count: 1'b0,
                                 is_last: 1'b0, error: 1'b0};
                        have_held  = 1'b1;
                        pend_byte  = '0;
                        pend_count = '0;
                     end else begin
                        pend_count++;
                     end
                  end
                  if (have_held) begin
                     held.is_last = 1'b1;
                     bytes_due.push_back(held);
                  end
               end
            end
            MODE_FLUSH: begin
               n_flushes++;
               if (pend_count != 3'd0) begin
                  bytes_due.push_back('{out_byte: pend_byte, is_count: 1'b0,
                                        is_last: 1'b0, error: 1'b0});
                  bytes_due.push_back('{out_byte: {5'd0, pend_count}, is_count: 1'b1,
                                        is_last: 1'b1, error: 1'b0});
                  pend_byte  = '0;
                  pend_count = '0;
               end
            end
            default: n_ignored++;
         endcase
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         mismatches++;
      endtask

      task check_result(result_type got);
         result_type want;
         n_checked++;
         if (bytes_due.size() == 0) begin
            report_mismatch($sformatf("unexpected result %0d, byte 0x%02h",
                                      n_checked, got.out_byte));
         end else begin
            want = bytes_due.pop_front();
            if (got.out_byte !== want.out_byte)
               report_mismatch($sformatf("result %0d out_byte 0x%02h, wanted 0x%02h",
                                         n_checked, got.out_byte, want.out_byte));
            if (got.is_count !== want.is_count)
               report_mismatch($sformatf("result %0d is_count %b, wanted %b",
                                         n_checked, got.is_count, want.is_count));
            if (got.is_last !== want.is_last)
               report_mismatch($sformatf("result %0d is_last %b, wanted %b",
                                         n_checked, got.is_last, want.is_last));
            if (got.error !== want.error)
               report_mismatch($sformatf("result %0d error %b, wanted %b",
                                         n_checked, got.error, want.error));
         end
      endtask
   endclass

   // ---------------------------------------------------------------------
   // Clock, reset and DUT
   // ---------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push;
   logic        req_full;
   logic [1:0]  req_mode;
   logic [7:0]  req_symbol;
   logic [15:0] req_code_word;
   logic [4:0]  req_code_length;
   logic        rsp_empty;
   logic        rsp_pop;
   logic [7:0]  rsp_out_byte;
   logic        rsp_is_count;
   logic        rsp_is_last;
   logic        rsp_error;

   always #(CLK_PERIOD / 2) clock = ~clock;

   huffman_code_packer_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_mode        (req_mode),
      .req_symbol      (req_symbol),
      .req_code_word   (req_code_word),
      .req_code_length (req_code_length),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_is_count    (rsp_is_count),
      .rsp_is_last     (rsp_is_last),
      .rsp_error       (rsp_error)
   );

   packer_scoreboard sb;

   // Idle rates in percent of cycles. The sender's is only touched by the
   // stimulus process; the receiver's is handed over by nonblocking write.
   int send_gap_pct;
   int recv_gap_pct;
   // Bumped by the stimulus side to ask the receiver for a long hold-off.
   int long_stall_requests = 0;
   int full_stall_cycles   = 0;
   int cycle_count         = 0;

   logic [7:0] symbol_pool [POOL_SIZE];

   // ---------------------------------------------------------------------
   // Watchdog: a hung block or a lost result ends the run here.
   // ---------------------------------------------------------------------
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles, %0d results still due",
               cycle_count, sb.outstanding());
      $display("Simulation FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Result side. Outputs are sampled at the edge (pre-update values), so a
   // result counts as taken exactly when pop was high and empty low there.
   // The long hold-off is counted here, in cycles, independent of the sender.
   // ---------------------------------------------------------------------
   initial begin : result_sink
      int         hold_left;
      int         stalls_seen;
      result_type got;
      hold_left   = 0;
      stalls_seen = 0;
      rsp_pop     = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            got.out_byte = rsp_out_byte;
            got.is_count = rsp_is_count;
            got.is_last  = rsp_is_last;
            got.error    = rsp_error;
            sb.check_result(got);
         end
         if (long_stall_requests != stalls_seen) begin
            stalls_seen = long_stall_requests;
            hold_left   = LONG_STALL_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= recv_gap_pct);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Offer one request, after a random number of idle cycles, and hold it
   // until an edge sees push high with full low. Returns in the time step
   // of that edge, so the next call may keep push high without a dip.
   task automatic send_request(input logic [1:0] mode, input logic [7:0] sym,
                               input logic [15:0] word, input logic [4:0] len);
      while ($urandom_range(99) < send_gap_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push        <= 1'b1;
      req_mode        <= mode;
      req_symbol      <= sym;
      req_code_word   <= word;
      req_code_length <= len;
      @(posedge clock);
      while (req_full) begin
         full_stall_cycles++;
         @(posedge clock);
      end
      sb.note_request(mode, sym, word, len);
   endtask

   // Stop offering and wait for every predicted result to be popped. At
   // least one edge passes so push is never lowered and raised in one step.
   task automatic wait_until_drained();
      req_push <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
   endtask

   // Code lengths for loads: mostly legal, some empty, some past the cap.
   function automatic logic [4:0] random_length();
      int pick;
      pick = $urandom_range(99);
      if (pick < 8)  return 5'd0;
      if (pick < 18) return 5'($urandom_range(31, 17));
      return 5'($urandom_range(16, 1));
   endfunction

   // Hand-picked opening: unknown symbol, empty flush, unused mode, all-ones
   // and all-zeros codes, empty code, saturated lengths, overwrite, and an
   // unknown symbol arriving with bits pending.
   task automatic run_directed();
      send_request(MODE_ENCODE, 8'h00, 16'h0000, 5'd0);    // nothing loaded yet
      send_request(MODE_FLUSH,  8'h00, 16'h0000, 5'd0);    // nothing pending
      send_request(MODE_UNUSED, 8'hFF, 16'hFFFF, 5'd31);
      send_request(MODE_LOAD,   8'h00, 16'hFFFF, 5'd16);
      send_request(MODE_LOAD,   8'hFF, 16'h0000, 5'd16);
      send_request(MODE_LOAD,   8'h5A, 16'h0005, 5'd3);
      send_request(MODE_LOAD,   8'h11, 16'hABCD, 5'd0);    // empty code
      send_request(MODE_LOAD,   8'h22, 16'h8001, 5'd31);   // saturates to 16
      send_request(MODE_LOAD,   8'h33, 16'h0001, 5'd1);
      send_request(MODE_ENCODE, 8'h00, 16'h0000, 5'd0);    // two 0xFF bytes
      send_request(MODE_ENCODE, 8'hFF, 16'hFFFF, 5'd31);   // two zero bytes
      send_request(MODE_ENCODE, 8'h11, 16'h0000, 5'd0);    // appends nothing
      send_request(MODE_ENCODE, 8'h5A, 16'h0000, 5'd0);
      send_request(MODE_FLUSH,  8'h00, 16'h0000, 5'd0);    // partial + count 3
      send_request(MODE_ENCODE, 8'h5A, 16'h0000, 5'd0);
      send_request(MODE_ENCODE, 8'h22, 16'h0000, 5'd0);    // straddles bytes
      send_request(MODE_FLUSH,  8'hFF, 16'hFFFF, 5'd31);
      send_request(MODE_LOAD,   8'h5A, 16'h00FF, 5'd8);    // overwrite
      send_request(MODE_ENCODE, 8'h5A, 16'h0000, 5'd0);
      send_request(MODE_UNUSED, 8'h00, 16'h0000, 5'd0);
      send_request(MODE_ENCODE, 8'h33, 16'h0000, 5'd0);
      send_request(MODE_LOAD,   8'h33, 16'hFFFF, 5'd17);   // just past the cap
      send_request(MODE_ENCODE, 8'h33, 16'h0000, 5'd0);
      send_request(MODE_ENCODE, 8'h7E, 16'h0000, 5'd0);    // miss, bits pending
      send_request(MODE_FLUSH,  8'h00, 16'h0000, 5'd0);
   endtask

   // Random requests, mostly encodes of symbols from a small loaded pool so
   // bytes keep completing; the rest are reloads, flushes, misses and noise.
   // Ignored (mode 3) requests do not count towards the total.
   task automatic run_random_phase(input int total, input bit load_pool,
                                   input int stall_at);
      int          sent;
      int          pick;
      bit          stall_fired;
      logic [1:0]  mode;
      logic [7:0]  sym;
      logic [15:0] word;
      logic [4:0]  len;
      sent        = 0;
      stall_fired = 1'b0;
      if (load_pool) begin
         for (int k = 0; k < POOL_SIZE; k++) begin
            symbol_pool[k] = 8'($urandom);
            send_request(MODE_LOAD, symbol_pool[k], 16'($urandom), random_length());
            sent++;
         end
      end
      while (sent < total) begin
         if (sent == stall_at && !stall_fired) begin
            // receiver holds off while requests keep coming: the queues fill
            long_stall_requests <= long_stall_requests + 1;
            stall_fired = 1'b1;
         end
         pick = $urandom_range(99);
         word = 16'($urandom);
         len  = 5'($urandom);
         if (pick < 3) begin
            mode = MODE_UNUSED;
            sym  = 8'($urandom);
         end else if (pick < 18) begin
            mode = MODE_LOAD;
            sym  = ($urandom_range(99) < 80) ? symbol_pool[$urandom_range(POOL_SIZE - 1)]
                                             : 8'($urandom);
            len  = random_length();
         end else if (pick < 88) begin
            mode = MODE_ENCODE;
            sym  = ($urandom_range(99) < 85) ? symbol_pool[$urandom_range(POOL_SIZE - 1)]
                                             : 8'($urandom);
         end else begin
            mode = MODE_FLUSH;
            sym  = 8'($urandom);
         end
         send_request(mode, sym, word, len);
         if (mode != MODE_UNUSED) sent++;
      end
   endtask

   // ---------------------------------------------------------------------
   // Run sequence: reset, directed opening, then three random phases with
   // different idle patterns, each started once all results have drained.
   // ---------------------------------------------------------------------
   initial begin : stimulus
      sb              = new();
      req_push        = 1'b0;
      req_mode        = MODE_LOAD;
      req_symbol      = '0;
      req_code_word   = '0;
      req_code_length = '0;
      send_gap_pct    = 37;
      recv_gap_pct    = 51;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      wait_until_drained();
      run_random_phase(PHASE_REQUESTS, 1'b1, 60);

      // sender idles more than the receiver now
      wait_until_drained();
      send_gap_pct = 51;
      recv_gap_pct <= 37;
      run_random_phase(PHASE_REQUESTS, 1'b0, -1);

      // full rate both ways, with a second long hold-off
      wait_until_drained();
      send_gap_pct = 0;
      recv_gap_pct <= 0;
      run_random_phase(PHASE_REQUESTS, 1'b0, 80);

      wait_until_drained();
      // any straggler popped here is flagged as unexpected by the sink
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d loads, %0d encodes (%0d unknown symbols), %0d flushes, %0d ignored",
               sb.n_loads, sb.n_encodes, sb.n_misses, sb.n_flushes, sb.n_ignored);
      $display("Checked %0d results with %0d mismatches; input held off %0d cycles by full",
               sb.n_checked, sb.mismatches, full_stall_cycles);
      if (sb.mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
